>>> src/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;

    localparam int unsigned QueueDepth = 4;

    // Item handed from the front part to the back part
    typedef struct packed {
        logic       finish;
        logic [7:0] data;
    } sha_item_t;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
        ror = (v >> n) | (v << (32 - n));
    endfunction

endpackage

>>> src/sha_queue.sv
`timescale 1ns / 1ps
module sha_queue #(
    parameter int unsigned DEPTH = sha_pkg::QueueDepth
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  sha_pkg::sha_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output sha_pkg::sha_item_t  out_item
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha_pkg::sha_item_t mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready  = (cnt_reg != (AW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Store pushed beats
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
            end
            if (pop) begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

>>> src/sha_core.sv
`timescale 1ns / 1ps
module sha_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  sha_pkg::sha_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        out_word,
    output logic [2:0]         out_index,
    output logic               out_last
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_LOAD  = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_ADD   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t      state_reg;
    // Block words while filling, rolling message schedule while compressing
    logic [31:0] w_reg [16];
    logic [5:0]  cnt_reg;
    logic [63:0] bits_reg;
    logic [63:0] total_reg;
    logic [31:0] h_reg [8];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, hh_reg;
    logic [5:0]  rnd_reg;
    logic [5:0]  pos_reg;
    logic        fin_reg;
    logic        fin_last_reg;
    logic [2:0]  oidx_reg;

    logic [31:0] w_cur, x15, x2, s0w, s1w, s1r, chr, s0r, mjr, t1, t2;
    logic [7:0]  pad_byte;

    // Replace one byte lane of a big-endian word
    function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] lane,
                                             input logic [7:0] value);
        logic [31:0] res;
        res = word;
        case (lane)
            2'd0:    res[31:24] = value;
            2'd1:    res[23:16] = value;
            2'd2:    res[15:8]  = value;
            default: res[7:0]   = value;
        endcase
        return res;
    endfunction

    // Round datapath
    always_comb begin
        x15 = w_reg[4'(rnd_reg - 6'd15)];
        x2  = w_reg[4'(rnd_reg - 6'd2)];
        s0w = sha_pkg::ror(x15, 7) ^ sha_pkg::ror(x15, 18) ^ (x15 >> 3);
        s1w = sha_pkg::ror(x2, 17) ^ sha_pkg::ror(x2, 19) ^ (x2 >> 10);
        if (rnd_reg < 6'd16) begin
            w_cur = w_reg[rnd_reg[3:0]];
        end else begin
            w_cur = w_reg[rnd_reg[3:0]] + s0w + w_reg[4'(rnd_reg - 6'd7)] + s1w;
        end
        s1r = sha_pkg::ror(e_reg, 6) ^ sha_pkg::ror(e_reg, 11) ^ sha_pkg::ror(e_reg, 25);
        chr = (e_reg & f_reg) ^ (~e_reg & g_reg);
        t1  = hh_reg + s1r + chr + sha_pkg::K_TAB[rnd_reg] + w_cur;
        s0r = sha_pkg::ror(a_reg, 2) ^ sha_pkg::ror(a_reg, 13) ^ sha_pkg::ror(a_reg, 22);
        mjr = (a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg);
        t2  = s0r + mjr;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_word  = h_reg[oidx_reg];
    assign out_index = oidx_reg;
    assign out_last  = (oidx_reg == 3'd7);

    // Padding byte for the current position
    always_comb begin
        if (pos_reg >= 6'd56 && fin_last_reg) begin
            pad_byte = total_reg[8 * (7 - int'(pos_reg[2:0])) +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            bits_reg  <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= sha_pkg::H_INIT[i];
            rnd_reg   <= '0;
            pos_reg   <= '0;
            fin_reg   <= 1'b0;
            fin_last_reg <= 1'b0;
            oidx_reg  <= '0;
        end else begin
            case (state_reg)
                // Take one beat: store a byte or start padding
                ST_IDLE: begin
                    if (in_valid) begin
                        if (!in_item.finish) begin
                            w_reg[cnt_reg[5:2]] <= put_byte(w_reg[cnt_reg[5:2]], cnt_reg[1:0],
                                                            in_item.data);
                            cnt_reg <= cnt_reg + 6'd1;
                            fin_reg <= 1'b0;
                            if (cnt_reg == 6'd63) begin
                                state_reg <= ST_LOAD;
                                bits_reg  <= bits_reg + 64'd512;
                            end
                        end else begin
                            w_reg[cnt_reg[5:2]] <= put_byte(w_reg[cnt_reg[5:2]], cnt_reg[1:0],
                                                            8'h80);
                            total_reg <= bits_reg + {55'd0, cnt_reg, 3'b000};
                            fin_reg   <= 1'b1;
                            fin_last_reg <= (cnt_reg < 6'd56);
                            pos_reg   <= cnt_reg + 6'd1;
                            if (cnt_reg == 6'd63) begin
                                state_reg <= ST_LOAD;
                            end else begin
                                state_reg <= ST_PAD;
                            end
                        end
                    end
                end
                // Fill one pad byte per cycle
                ST_PAD: begin
                    w_reg[pos_reg[5:2]] <= put_byte(w_reg[pos_reg[5:2]], pos_reg[1:0], pad_byte);
                    pos_reg <= pos_reg + 6'd1;
                    if (pos_reg == 6'd63) begin
                        state_reg <= ST_LOAD;
                    end
                end
                // Load the working variables from the chaining value
                ST_LOAD: begin
                    a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                    d_reg <= h_reg[3]; e_reg <= h_reg[4]; f_reg <= h_reg[5];
                    g_reg <= h_reg[6]; hh_reg <= h_reg[7];
                    rnd_reg   <= '0;
                    state_reg <= ST_ROUND;
                end
                // One round per cycle
                ST_ROUND: begin
                    w_reg[rnd_reg[3:0]] <= w_cur;
                    hh_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg; e_reg <= d_reg + t1;
                    d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg; a_reg <= t1 + t2;
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63) begin
                        state_reg <= ST_ADD;
                    end
                end
                // Fold working variables into the chaining value
                ST_ADD: begin
                    h_reg[0] <= h_reg[0] + a_reg; h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg; h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg; h_reg[5] <= h_reg[5] + f_reg;
                    h_reg[6] <= h_reg[6] + g_reg; h_reg[7] <= h_reg[7] + hh_reg;
                    oidx_reg <= '0;
                    if (!fin_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (!fin_last_reg) begin
                        fin_last_reg <= 1'b1;
                        pos_reg   <= '0;
                        state_reg <= ST_PAD;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                // Emit the digest, then start a new message
                ST_OUT: begin
                    if (out_ready) begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7) begin
                            state_reg <= ST_IDLE;
                            cnt_reg   <= '0;
                            bits_reg  <= '0;
                            for (int i = 0; i < 8; i++) h_reg[i] <= sha_pkg::H_INIT[i];
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> src/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
// Channel  Dir  Contents
// s_       in   tdata[7:0] data_byte, tuser action (1 = finish)
// m_       out  tdata[31:0] digest_word, tuser[2:0] word_index, tlast last_word
// A beat is registered in the queue before the core sees it; the core then stores each absorbed byte.
// The 64th byte of a block starts a compression: load, 64 rounds, fold.
// A finish pads one byte per cycle up to byte 63, compresses, and with more than 55
// bytes pending pads a second 64-byte block and compresses again; eight beats follow.
// The queue keeps taking beats while the core is busy; s_tready drops when it is full.
// Reset is synchronous, active low, and restores the initial hash values.
module sha256_byte_stream_hasher #(
    parameter int unsigned QUEUE_DEPTH = sha_pkg::QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);
    sha_pkg::sha_item_t in_item, q_item;
    logic q_valid, q_ready;

    assign in_item.finish = s_tuser;
    assign in_item.data   = s_tdata;

    sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    sha_core u_core (
        .aclk, .aresetn,
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_word(m_tdata), .out_index(m_tuser), .out_last(m_tlast)
    );
endmodule
